FILE: design/s2d_pkg.sv
package s2d_pkg;

    localparam int VALUE_BITS  = 32;
    // decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
    localparam int NUM_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS    = 4 * NUM_DIGITS;
    localparam int CNT_W       = $clog2(VALUE_BITS);
    localparam int POS_W       = $clog2(NUM_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int CHAR_BITS   = 6;

    localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(45);
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = CHAR_BITS'(48);

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_job;

endpackage

FILE: design/s2d_if.sv
interface s2d_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [s2d_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if;
    logic                               valid;
    logic                               ready;
    logic [s2d_pkg::CHAR_BITS-1:0]      text_char;
    logic                               last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

FILE: design/signed_int_to_decimal_ascii_core.sv
// Flow: a beat accepted into the two-entry queue is loaded by an idle converter, which
//   runs 32 steps of the shift-add-3 converter, then a sign state for a negative value,
//   then ten digit positions, where leading zero positions are skipped without a beat.
// The queue takes new numbers while the converter works on one; an output stall holds
//   the sign and digit states until the sink is ready.
// Reset (synchronous, active low) empties the two-entry queue and idles the converter.
module signed_int_to_decimal_ascii_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2d_in_if.sink      i_in,
    s2d_out_if.source   o_out
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    s2d_pkg::t_job job_in;
    s2d_pkg::t_job job_out;

    s2d_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (job_in)
    );

    s2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    s2d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: design/s2d_front.sv
module s2d_front (
    s2d_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output s2d_pkg::t_job  o_job
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // two's complement negate; the most negative value maps to 2^(N-1) unsigned
    always_comb begin
        o_job.neg = i_in.value[s2d_pkg::VALUE_BITS-1];
        o_job.mag = o_job.neg ? (~i_in.value + 1'b1) : i_in.value;
    end

endmodule

FILE: design/s2d_fifo.sv
module s2d_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  s2d_pkg::t_job  i_job,
    input  logic           i_pop,
    output s2d_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PTR_W = (s2d_pkg::QUEUE_DEPTH > 1) ? $clog2(s2d_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(s2d_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(s2d_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(s2d_pkg::QUEUE_DEPTH);

    s2d_pkg::t_job    r_mem [s2d_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");
`endif

endmodule

FILE: design/s2d_back.sv
module s2d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  s2d_pkg::t_job  i_job,
    output logic           o_pop,
    s2d_out_if.source      o_out
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CONV   = 4'b0010,
        S_SIGN   = 4'b0100,
        S_DIGITS = 4'b1000
    } t_state;

    localparam logic [s2d_pkg::CNT_W-1:0] CNT_LAST = s2d_pkg::CNT_W'(s2d_pkg::VALUE_BITS - 1);
    localparam logic [s2d_pkg::POS_W-1:0] POS_LAST = s2d_pkg::POS_W'(s2d_pkg::NUM_DIGITS - 1);

    t_state                          r_state, n_state;
    logic                            r_neg, n_neg;
    logic [s2d_pkg::VALUE_BITS-1:0]  r_sh, n_sh;
    logic [s2d_pkg::BCD_BITS-1:0]    r_bcd, n_bcd;
    logic [s2d_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [s2d_pkg::POS_W-1:0]       r_pos, n_pos;
    logic                            r_started, n_started;
    logic                            r_ovalid, n_ovalid;
    logic [s2d_pkg::CHAR_BITS-1:0]   r_char, n_char;
    logic                            r_last, n_last;

    logic                            adv;
    logic                            pos_last;
    logic [3:0]                      digit;
    logic [s2d_pkg::BCD_BITS-1:0]    adj;

    assign o_out.valid     = r_ovalid;
    assign o_out.text_char = r_char;
    assign o_out.last      = r_last;

    assign adv      = !r_ovalid || o_out.ready;
    assign digit    = r_bcd[s2d_pkg::BCD_BITS-1 -: 4];
    assign pos_last = (r_pos == POS_LAST);

    // add-3 correction, digits independent
    always_comb begin
        for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_sh      = r_sh;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_started = r_started;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_char    = r_char;
        n_last    = r_last;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_neg   = i_job.neg;
                    n_sh    = i_job.mag;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {adj[s2d_pkg::BCD_BITS-2:0], r_sh[s2d_pkg::VALUE_BITS-1]};
                n_sh  = {r_sh[s2d_pkg::VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_pos     = '0;
                    n_started = 1'b0;
                    n_state   = r_neg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN: begin
                if (adv) begin
                    n_ovalid = 1'b1;
                    n_char   = s2d_pkg::CH_MINUS;
                    n_last   = 1'b0;
                    n_state  = S_DIGITS;
                end
            end
            S_DIGITS: begin
                // leading zeros are dropped without a beat; the units digit always goes out
                if (digit == 4'd0 && !r_started && !pos_last) begin
                    n_bcd = {r_bcd[s2d_pkg::BCD_BITS-5:0], 4'd0};
                    n_pos = r_pos + 1'b1;
                end else if (adv) begin
                    n_ovalid  = 1'b1;
                    n_char    = s2d_pkg::CH_ZERO + {2'b00, digit};
                    n_last    = pos_last;
                    n_started = 1'b1;
                    n_bcd     = {r_bcd[s2d_pkg::BCD_BITS-5:0], 4'd0};
                    n_pos     = r_pos + 1'b1;
                    if (pos_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= n_neg;
        r_sh      <= n_sh;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_pos     <= n_pos;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

`ifndef ASSERT_OFF
    a_units_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGITS && pos_last && adv) |=> (r_ovalid && r_last))
        else $error("units digit not flagged last");
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_char == s2d_pkg::CH_MINUS) |-> !r_last)
        else $error("minus sign flagged last");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_empty))
        else $error("queue pop outside idle");
`endif

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [s2d_pkg::VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [s2d_pkg::CHAR_BITS-1:0] text_char;
        logic                          last;
    } t_char_beat;

    localparam t_value MAX_VALUE      = {1'b0, {(s2d_pkg::VALUE_BITS-1){1'b1}}};
    localparam t_value MIN_VALUE      = {1'b1, {(s2d_pkg::VALUE_BITS-1){1'b0}}};
    localparam int     RADIX          = 10;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    s2d_in_if  in_bus ();
    s2d_out_if out_bus ();

    signed_int_to_decimal_ascii_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_char_beat expected_text[$];
    t_char_beat head_beat;
    int         error_count    = 0;
    int         send_idle_pct  = 15;
    int         recv_stall_pct = 85;
    int         quiet_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sink side: random backpressure
    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // decimal text of one value, sign first, no leading zeros
    function automatic void predict_text(input t_value v);
        logic [s2d_pkg::VALUE_BITS:0] mag;
        logic [3:0]                   digit_q[$];
        t_char_beat                   beat;
        logic                         neg;
        neg = v[s2d_pkg::VALUE_BITS-1];
        // one extra bit so the most negative value keeps its magnitude
        mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        do begin
            digit_q.push_front(4'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        if (neg) begin
            beat.text_char = s2d_pkg::CH_MINUS;
            beat.last      = 1'b0;
            expected_text.push_back(beat);
        end
        foreach (digit_q[i]) begin
            beat.text_char = s2d_pkg::CH_ZERO + s2d_pkg::CHAR_BITS'(digit_q[i]);
            beat.last      = (i == digit_q.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    task automatic send_value(input t_value v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.value <= v;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_text(v);
    endtask

    task automatic wait_for_text_drain();
        in_bus.valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_value random_value();
        longint      lo;
        longint      hi;
        longint      mag;
        int unsigned n_digits;
        case ($urandom_range(3))
            0: begin
                return t_value'($urandom);
            end
            1: begin
                // uniform over digit count, then over values of that length
                n_digits = $urandom_range(10, 1);
                lo = 1;
                repeat (n_digits - 1) lo = lo * RADIX;
                hi = lo * RADIX - 1;
                if (n_digits == 1) lo = 0;
                if (hi > longint'(MAX_VALUE)) hi = longint'(MAX_VALUE);
                mag = lo + longint'($urandom_range(int'(hi - lo)));
                return t_value'($urandom_range(1) ? -mag : mag);
            end
            2: begin
                if ($urandom_range(1))
                    return MIN_VALUE + t_value'($urandom_range(15));
                return MAX_VALUE - t_value'($urandom_range(15));
            end
            default: begin
                return t_value'(int'($urandom_range(2000)) - 1000);
            end
        endcase
    endfunction

    task automatic test_extremes();
        send_value('0);
        send_value(t_value'(1));
        send_value(t_value'(-1));
        send_value(MAX_VALUE);
        send_value(MIN_VALUE);
        send_value(MIN_VALUE + t_value'(1));
        send_value(MAX_VALUE - t_value'(1));
        send_value(t_value'(32'h5555_5555));
        send_value(t_value'(32'hAAAA_AAAA));
    endtask

    task automatic test_digit_counts();
        send_value(t_value'(9));
        send_value(t_value'(10));
        send_value(t_value'(-9));
        send_value(t_value'(-10));
        send_value(t_value'(99));
        send_value(t_value'(100));
        send_value(t_value'(999999999));
        send_value(t_value'(1000000000));
        send_value(t_value'(-999999999));
        send_value(t_value'(-1000000000));
        send_value(t_value'(1234567890));
        send_value(t_value'(-987654321));
    endtask

    // sender holds off until the converter and output side are empty
    task automatic test_pause_until_drained();
        send_value(t_value'(-42));
        send_value(t_value'(7));
        wait_for_text_drain();
        send_value(MIN_VALUE);
        send_value('0);
    endtask

    task automatic test_random_values(input int count, input int idle_pct,
                                      input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_value(random_value());
        wait_for_text_drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected char: expected none, actual %0d last %0b",
                         $time, out_bus.text_char, out_bus.last);
                error_count++;
            end else begin
                head_beat = expected_text.pop_front();
                if (out_bus.text_char !== head_beat.text_char) begin
                    $display("%0t: text_char mismatch: expected %0d, actual %0d",
                             $time, head_beat.text_char, out_bus.text_char);
                    error_count++;
                end
                if (out_bus.last !== head_beat.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, head_beat.last, out_bus.last);
                    error_count++;
                end
            end
        end
    end

    // no beat on either side for too long means the block is stuck
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_digit_counts();
        test_pause_until_drained();
        test_random_values(130, 15, 85);
        test_random_values(130, 85, 15);
        test_random_values(140, 0, 0);
        wait_for_text_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_text.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/s2d_pkg.sv
design/s2d_if.sv
design/s2d_front.sv
design/s2d_fifo.sv
design/s2d_back.sv
design/signed_int_to_decimal_ascii_core.sv
tb/tb.sv
